### rtl/srs_pkg.sv
// Shared types and codes for the sparse register shadow.
// No dependencies; imported by the block, srs_shadow_checker and the testbench top.
package srs_pkg;

   // access kinds on req_mode
   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_PEEK  = 2'd2;

   // result source codes on rsp_source
   localparam logic [2:0] SRC_CLAIMED = 3'd0;
   localparam logic [2:0] SRC_STORED  = 3'd1;
   localparam logic [2:0] SRC_MASKED  = 3'd2;
   localparam logic [2:0] SRC_TOGGLE  = 3'd3;
   localparam logic [2:0] SRC_WROTE   = 3'd4;
   localparam logic [2:0] SRC_DROPPED = 3'd5;

   // register indexes on csr_index
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIPH_BASE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUIRK_A     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUIRK_B     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_QUIRK_MASK  = 3'd4;

   // register reset values
   localparam logic [31:0] RST_PERIPH_BASE = 32'h4000_0000;
   localparam logic [7:0]  RST_SETTLE      = 8'd8;
   localparam logic [31:0] RST_QUIRK_A     = 32'h4013_C004;
   localparam logic [31:0] RST_QUIRK_B     = 32'h4013_C008;
   localparam logic [31:0] RST_QUIRK_MASK  = 32'h00FF_FFFF;

   localparam int unsigned RUN_W   = 9;
   localparam logic [RUN_W-1:0] RUN_MAX = 9'd511;
   localparam int unsigned DIST_W  = 12;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // one hash bucket of the slot memory
   typedef struct packed {
      logic        occupied;
      logic        written;
      logic [31:0] address;
      logic [31:0] value;
   } srs_entry_type;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_HASH   = 5'b00100,
      ST_PROBE  = 5'b01000,
      ST_UPDATE = 5'b10000
   } srs_state_type;

endpackage

### rtl/sparse_register_shadow_with_poll_settle.sv
// Sparse register shadow: top level, slot memory and request sequencer.
// Depends on srs_pkg.
//
// Shadows bus requests to registers that no modelled block owns. Each request
// address (periph_base + offset, mod 2^32) lives in one bucket of an
// open-addressed hash table of SLOT_COUNT buckets held in a single-port-write,
// registered-read memory; collisions probe linearly to the next bucket. A
// request steps through accept, hash and read, probe compare, and update and
// write back, repeating the probe compare for each further bucket on the
// probe chain, which is longest with the table full and the address absent.
// Claimed reads and writes and unknown-mode requests skip the memory and go
// from accept straight to update. After reset the block sweeps the memory to
// mark all buckets empty with req_ready low; csr writes are taken throughout.
// One request is in flight at a time, so the write back of one request always
// lands before the next request reads the memory. A finished response waits
// in the output register while the next request is accepted and looked up.
module sparse_register_shadow_with_poll_settle #(
   parameter int unsigned SLOT_COUNT = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_we,
   input  logic [srs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_wdata,
   // requests
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic [31:0]                       req_address_offset,
   input  logic [31:0]                       req_write_value,
   input  logic                              req_claimed,
   // responses
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [31:0]                       rsp_read_data,
   output logic [2:0]                        rsp_source,
   output logic [31:0]                       rsp_total_reads,
   output logic [31:0]                       rsp_total_writes,
   output logic [srs_pkg::DIST_W-1:0]        rsp_distinct_addresses
);
   import srs_pkg::*;

   localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
   localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   // fold the 32-bit address onto the bucket index, then bring it into range
   function automatic logic [IDX_W-1:0] bucket_of(input logic [31:0] a);
      logic [IDX_W-1:0] h;
      logic [IDX_W:0]   w;
      h = '0;
      for (int i = 0; i < 32; i++) begin
         h[i % IDX_W] = h[i % IDX_W] ^ a[i];
      end
      w = {1'b0, h};
      if (w >= (IDX_W + 1)'(SLOT_COUNT)) begin
         w = w - (IDX_W + 1)'(SLOT_COUNT);
      end
      return w[IDX_W-1:0];
   endfunction

   // configuration registers
   logic [31:0] base_ff, base_in;
   logic [7:0]  settle_ff, settle_in;
   logic [31:0] quirk_a_ff, quirk_a_in;
   logic [31:0] quirk_b_ff, quirk_b_in;
   logic [31:0] quirk_mask_ff, quirk_mask_in;

   // control state
   srs_state_type      state_ff, state_in;
   logic [IDX_W-1:0]   clr_idx_ff, clr_idx_in;
   logic [CNT_W-1:0]   slots_used_ff, slots_used_in;
   logic [IDX_W-1:0]   run_slot_ff, run_slot_in;
   logic               run_valid_ff, run_valid_in;
   logic [RUN_W-1:0]   run_len_ff, run_len_in;
   logic [31:0]        toggle_ff, toggle_in;
   logic [31:0]        read_total_ff, read_total_in;
   logic [31:0]        write_total_ff, write_total_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // request payload and lookup results
   logic [1:0]         mode_ff, mode_in;
   logic [31:0]        addr_ff, addr_in;
   logic [31:0]        wval_ff, wval_in;
   logic               claimed_ff, claimed_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   probe_cnt_ff, probe_cnt_in;
   logic               hit_ff, hit_in;
   logic               empty_ff, empty_in;
   logic               ent_written_ff, ent_written_in;
   logic [31:0]        ent_value_ff, ent_value_in;

   // response register
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic [2:0]         rsp_source_ff, rsp_source_in;
   logic [31:0]        rsp_reads_ff, rsp_reads_in;
   logic [31:0]        rsp_writes_ff, rsp_writes_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;

   // slot memory
   srs_entry_type      slot_mem_ff [SLOT_COUNT];
   srs_entry_type      rd_data_ff;
   logic [IDX_W-1:0]   rd_idx;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   srs_entry_type      mem_wd;

   // decode of the request in flight
   logic               is_read, is_write, is_peek, active, slot_ok;
   logic               same_run, stored_ok, is_quirk;
   logic [RUN_W-1:0]   run_len_touch;
   logic               probe_match, probe_empty, probe_last;
   logic [IDX_W-1:0]   idx_step, hash_idx;
   logic [31:0]        reads_next, writes_next;
   logic [CNT_W-1:0]   slots_next;

   assign is_read  = (mode_ff == MODE_READ);
   assign is_write = (mode_ff == MODE_WRITE);
   assign is_peek  = (mode_ff == MODE_PEEK);
   assign active   = (is_read | is_write) & ~claimed_ff;
   assign slot_ok  = hit_ff | empty_ff;      // found, or freshly allocated

   // run of consecutive requests on one bucket; buckets never move, so
   // comparing indexes is comparing addresses
   assign same_run = run_valid_ff && (run_slot_ff == idx_ff);
   assign run_len_touch = !same_run ? RUN_W'(1) :
                          (run_len_ff == RUN_MAX) ? run_len_ff : run_len_ff + RUN_W'(1);
   assign stored_ok = hit_ff & ent_written_ff & (run_len_touch <= {1'b0, settle_ff});
   assign is_quirk  = (addr_ff == quirk_a_ff) || (addr_ff == quirk_b_ff);

   assign probe_match = rd_data_ff.occupied && (rd_data_ff.address == addr_ff);
   assign probe_empty = ~rd_data_ff.occupied;
   assign probe_last  = (probe_cnt_ff == LAST_IDX);
   assign idx_step    = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
   assign hash_idx    = bucket_of(addr_ff);

   assign reads_next  = read_total_ff + 32'(is_read);
   assign writes_next = write_total_ff + 32'(is_write);
   assign slots_next  = slots_used_ff + CNT_W'(active & empty_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_read_data          = rsp_data_ff;
   assign rsp_source             = rsp_source_ff;
   assign rsp_total_reads        = rsp_reads_ff;
   assign rsp_total_writes       = rsp_writes_ff;
   assign rsp_distinct_addresses = rsp_dist_ff;

   always_comb begin
      base_in        = base_ff;
      settle_in      = settle_ff;
      quirk_a_in     = quirk_a_ff;
      quirk_b_in     = quirk_b_ff;
      quirk_mask_in  = quirk_mask_ff;
      state_in       = state_ff;
      clr_idx_in     = clr_idx_ff;
      slots_used_in  = slots_used_ff;
      run_slot_in    = run_slot_ff;
      run_valid_in   = run_valid_ff;
      run_len_in     = run_len_ff;
      toggle_in      = toggle_ff;
      read_total_in  = read_total_ff;
      write_total_in = write_total_ff;
      rsp_valid_in   = rsp_valid_ff;
      mode_in        = mode_ff;
      addr_in        = addr_ff;
      wval_in        = wval_ff;
      claimed_in     = claimed_ff;
      idx_in         = idx_ff;
      probe_cnt_in   = probe_cnt_ff;
      hit_in         = hit_ff;
      empty_in       = empty_ff;
      ent_written_in = ent_written_ff;
      ent_value_in   = ent_value_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_source_in  = rsp_source_ff;
      rsp_reads_in   = rsp_reads_ff;
      rsp_writes_in  = rsp_writes_ff;
      rsp_dist_in    = rsp_dist_ff;
      rd_idx         = idx_step;
      mem_we         = 1'b0;
      mem_wa         = idx_ff;
      mem_wd         = '0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_PERIPH_BASE: base_in       = csr_wdata;
            CSR_SETTLE:      settle_in     = csr_wdata[7:0];
            CSR_QUIRK_A:     quirk_a_in    = csr_wdata;
            CSR_QUIRK_B:     quirk_b_in    = csr_wdata;
            CSR_QUIRK_MASK:  quirk_mask_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // mark every bucket empty, one per cycle
            mem_we = 1'b1;
            mem_wa = clr_idx_ff;
            if (clr_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in    = req_mode;
               addr_in    = base_ff + req_address_offset;
               wval_in    = req_write_value;
               claimed_in = req_claimed;
               hit_in     = 1'b0;
               empty_in   = 1'b0;
               if (req_mode == MODE_PEEK ||
                   ((req_mode == MODE_READ || req_mode == MODE_WRITE) && !req_claimed)) begin
                  state_in = ST_HASH;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_HASH: begin
            rd_idx       = hash_idx;
            idx_in       = hash_idx;
            probe_cnt_in = '0;
            state_in     = ST_PROBE;
         end
         ST_PROBE: begin
            ent_written_in = rd_data_ff.written;
            ent_value_in   = rd_data_ff.value;
            if (probe_match) begin
               hit_in   = 1'b1;
               state_in = ST_UPDATE;
            end else if (probe_empty) begin
               // an empty bucket ends the chain: the address is new
               empty_in = 1'b1;
               state_in = ST_UPDATE;
            end else if (probe_last) begin
               // whole table walked: full and absent
               state_in = ST_UPDATE;
            end else begin
               idx_in       = idx_step;
               probe_cnt_in = probe_cnt_ff + IDX_W'(1);
            end
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               read_total_in  = reads_next;
               write_total_in = writes_next;
               slots_used_in  = slots_next;
               rsp_data_in    = '0;
               rsp_source_in  = SRC_CLAIMED;
               if (is_peek) begin
                  rsp_source_in = SRC_STORED;
                  if (hit_ff && ent_written_ff) begin
                     rsp_data_in = ent_value_ff;
                  end
               end else if (active) begin
                  if (slot_ok) begin
                     run_slot_in  = idx_ff;
                     run_valid_in = 1'b1;
                     run_len_in   = run_len_touch;
                  end
                  if (is_write) begin
                     if (slot_ok) begin
                        mem_we        = 1'b1;
                        mem_wd        = '{occupied: 1'b1, written: 1'b1,
                                          address: addr_ff, value: wval_ff};
                        rsp_source_in = SRC_WROTE;
                     end else begin
                        rsp_source_in = SRC_DROPPED;
                     end
                  end else begin
                     if (empty_ff) begin
                        // allocate on read: present but never written
                        mem_we = 1'b1;
                        mem_wd = '{occupied: 1'b1, written: 1'b0,
                                   address: addr_ff, value: 32'd0};
                     end
                     if (stored_ok) begin
                        if (is_quirk) begin
                           rsp_data_in   = ent_value_ff & quirk_mask_ff;
                           rsp_source_in = SRC_MASKED;
                        end else begin
                           rsp_data_in   = ent_value_ff;
                           rsp_source_in = SRC_STORED;
                        end
                     end else begin
                        toggle_in     = toggle_ff ^ ALL_ONES;
                        rsp_data_in   = toggle_ff ^ ALL_ONES;
                        rsp_source_in = SRC_TOGGLE;
                     end
                  end
               end
               rsp_reads_in  = reads_next;
               rsp_writes_in = writes_next;
               rsp_dist_in   = DIST_W'(slots_next);
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff        <= RST_PERIPH_BASE;
         settle_ff      <= RST_SETTLE;
         quirk_a_ff     <= RST_QUIRK_A;
         quirk_b_ff     <= RST_QUIRK_B;
         quirk_mask_ff  <= RST_QUIRK_MASK;
         state_ff       <= ST_CLEAR;
         clr_idx_ff     <= '0;
         slots_used_ff  <= '0;
         run_slot_ff    <= '0;
         run_valid_ff   <= 1'b0;
         run_len_ff     <= '0;
         toggle_ff      <= '0;
         read_total_ff  <= '0;
         write_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         base_ff        <= base_in;
         settle_ff      <= settle_in;
         quirk_a_ff     <= quirk_a_in;
         quirk_b_ff     <= quirk_b_in;
         quirk_mask_ff  <= quirk_mask_in;
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         slots_used_ff  <= slots_used_in;
         run_slot_ff    <= run_slot_in;
         run_valid_ff   <= run_valid_in;
         run_len_ff     <= run_len_in;
         toggle_ff      <= toggle_in;
         read_total_ff  <= read_total_in;
         write_total_ff <= write_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      addr_ff        <= addr_in;
      wval_ff        <= wval_in;
      claimed_ff     <= claimed_in;
      idx_ff         <= idx_in;
      probe_cnt_ff   <= probe_cnt_in;
      hit_ff         <= hit_in;
      empty_ff       <= empty_in;
      ent_written_ff <= ent_written_in;
      ent_value_ff   <= ent_value_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_source_ff  <= rsp_source_in;
      rsp_reads_ff   <= rsp_reads_in;
      rsp_writes_ff  <= rsp_writes_in;
      rsp_dist_ff    <= rsp_dist_in;
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem_ff[rd_idx];
   end

endmodule

### dv/srs_shadow_checker.sv
// Response checker for the sparse register shadow: follows csr writes, predicts
// each response from the accepted requests and compares in arrival order.
// Depends on srs_pkg.
module srs_shadow_checker #(
   parameter int unsigned SLOT_COUNT = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [srs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [31:0]                   req_address_offset,
   input  logic [31:0]                   req_write_value,
   input  logic                          req_claimed,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [31:0]                   rsp_read_data,
   input  logic [2:0]                    rsp_source,
   input  logic [31:0]                   rsp_total_reads,
   input  logic [31:0]                   rsp_total_writes,
   input  logic [srs_pkg::DIST_W-1:0]    rsp_distinct_addresses,
   output int unsigned                   mismatch_count,
   output int unsigned                   owed_count
);
   import srs_pkg::*;

   typedef struct packed {
      logic [31:0]       read_data;
      logic [2:0]        source;
      logic [31:0]       reads;
      logic [31:0]       writes;
      logic [DIST_W-1:0] distinct;
   } shadow_rsp_type;

   // register copies
   logic [31:0] base_cfg;
   logic [7:0]  settle_cfg;
   logic [31:0] quirk_a_cfg;
   logic [31:0] quirk_b_cfg;
   logic [31:0] quirk_mask_cfg;

   // shadow table: address -> slot number, in allocation order
   int          slot_of [bit [31:0]];
   logic [31:0] slot_val [SLOT_COUNT];
   bit          slot_wr [SLOT_COUNT];
   int unsigned used_slots;

   int               run_idx;
   bit               run_live;
   logic [RUN_W-1:0] run_len;
   logic [31:0]      toggle_val;
   logic [31:0]      read_count;
   logic [31:0]      write_count;

   shadow_rsp_type owed_q [$];
   int unsigned errs;

   // -1 when the address is absent and no slot is left
   function automatic int claim_slot(logic [31:0] addr);
      int n;
      if (slot_of.exists(addr)) return slot_of[addr];
      if (used_slots >= SLOT_COUNT) return -1;
      n = used_slots;
      slot_of[addr] = n;
      slot_val[n] = '0;
      slot_wr[n] = 1'b0;
      used_slots++;
      return n;
   endfunction

   function automatic void extend_run(int idx);
      if (run_live && run_idx == idx) begin
         if (run_len != RUN_MAX) run_len++;
      end else begin
         run_idx = idx;
         run_live = 1'b1;
         run_len = RUN_W'(1);
      end
   endfunction

   function automatic shadow_rsp_type shadow_response(logic [1:0] mode, logic [31:0] offset,
                                                      logic [31:0] wval, logic claimed);
      shadow_rsp_type r;
      logic [31:0] addr;
      int idx;
      r = '0;
      addr = base_cfg + offset;
      case (mode)
         MODE_READ: begin
            read_count++;
            if (!claimed) begin
               idx = claim_slot(addr);
               r.source = SRC_TOGGLE;
               if (idx >= 0) begin
                  extend_run(idx);
                  if (slot_wr[idx] && run_len <= settle_cfg) begin
                     if (addr == quirk_a_cfg || addr == quirk_b_cfg) begin
                        r.read_data = slot_val[idx] & quirk_mask_cfg;
                        r.source = SRC_MASKED;
                     end else begin
                        r.read_data = slot_val[idx];
                        r.source = SRC_STORED;
                     end
                  end
               end
               if (r.source == SRC_TOGGLE) begin
                  toggle_val = ~toggle_val;
                  r.read_data = toggle_val;
               end
            end
         end
         MODE_WRITE: begin
            write_count++;
            if (!claimed) begin
               idx = claim_slot(addr);
               if (idx >= 0) begin
                  slot_val[idx] = wval;
                  slot_wr[idx] = 1'b1;
                  extend_run(idx);
                  r.source = SRC_WROTE;
               end else begin
                  r.source = SRC_DROPPED;
               end
            end
         end
         MODE_PEEK: begin
            // no side effects, claimed ignored, raw value
            r.source = SRC_STORED;
            if (slot_of.exists(addr)) begin
               idx = slot_of[addr];
               if (slot_wr[idx]) r.read_data = slot_val[idx];
            end
         end
         default: ;
      endcase
      r.reads = read_count;
      r.writes = write_count;
      r.distinct = used_slots[DIST_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errs++;
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin : track
      shadow_rsp_type want;
      if (reset) begin
         base_cfg = RST_PERIPH_BASE;
         settle_cfg = RST_SETTLE;
         quirk_a_cfg = RST_QUIRK_A;
         quirk_b_cfg = RST_QUIRK_B;
         quirk_mask_cfg = RST_QUIRK_MASK;
         slot_of.delete();
         used_slots = 0;
         run_idx = 0;
         run_live = 1'b0;
         run_len = '0;
         toggle_val = '0;
         read_count = '0;
         write_count = '0;
         owed_q.delete();
         errs = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PERIPH_BASE: base_cfg = csr_wdata;
               CSR_SETTLE:      settle_cfg = csr_wdata[7:0];
               CSR_QUIRK_A:     quirk_a_cfg = csr_wdata;
               CSR_QUIRK_B:     quirk_b_cfg = csr_wdata;
               CSR_QUIRK_MASK:  quirk_mask_cfg = csr_wdata;
               default: ;
            endcase
         end
         // responses never leave in the cycle their request is taken,
         // so retire before queueing
         if (rsp_valid && rsp_ready) begin
            if (owed_q.size() == 0) begin
               errs++;
               $error("response with no request outstanding");
            end else begin
               want = owed_q.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("source", 32'(want.source), 32'(rsp_source));
               check_field("total_reads", want.reads, rsp_total_reads);
               check_field("total_writes", want.writes, rsp_total_writes);
               check_field("distinct_addresses", 32'(want.distinct),
                           32'(rsp_distinct_addresses));
            end
         end
         if (req_valid && req_ready)
            owed_q.push_back(shadow_response(req_mode, req_address_offset,
                                             req_write_value, req_claimed));
      end
      owed_count <= owed_q.size();
      mismatch_count <= errs;
   end

endmodule

### dv/tb_sparse_register_shadow_with_poll_settle.sv
// Testbench top for sparse_register_shadow_with_poll_settle: clock, reset,
// request and csr stimulus, response back-pressure and the verdict.
// Depends on srs_pkg, the block and srs_shadow_checker.
module tb_sparse_register_shadow_with_poll_settle;
   import srs_pkg::*;

   localparam int unsigned SLOT_COUNT = 2048;
   // fourth access kind: block must answer it without touching state
   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam logic [31:0] QA_OFF = RST_QUIRK_A - RST_PERIPH_BASE;
   localparam logic [31:0] QB_OFF = RST_QUIRK_B - RST_PERIPH_BASE;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_mode = MODE_READ;
   logic [31:0]          req_address_offset = '0;
   logic [31:0]          req_write_value = '0;
   logic                 req_claimed = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [31:0]          rsp_read_data;
   logic [2:0]           rsp_source;
   logic [31:0]          rsp_total_reads;
   logic [31:0]          rsp_total_writes;
   logic [DIST_W-1:0]    rsp_distinct_addresses;

   int unsigned mismatch_count;
   int unsigned owed_count;

   // stimulus-side view of the programmed registers
   logic [31:0] cur_base = RST_PERIPH_BASE;
   logic [31:0] cur_qa = RST_QUIRK_A;
   logic [31:0] cur_qb = RST_QUIRK_B;
   logic [7:0]  cur_settle = RST_SETTLE;

   int unsigned       send_calm = 0;
   int unsigned       rsp_calm = 0;
   int unsigned       rsp_hold = 0;

   always #10 clock = ~clock;

   sparse_register_shadow_with_poll_settle #(
      .SLOT_COUNT(SLOT_COUNT)
   ) DUT (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode               (req_mode),
      .req_address_offset     (req_address_offset),
      .req_write_value        (req_write_value),
      .req_claimed            (req_claimed),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_read_data          (rsp_read_data),
      .rsp_source             (rsp_source),
      .rsp_total_reads        (rsp_total_reads),
      .rsp_total_writes       (rsp_total_writes),
      .rsp_distinct_addresses (rsp_distinct_addresses)
   );

   srs_shadow_checker #(
      .SLOT_COUNT(SLOT_COUNT)
   ) checker_i (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode               (req_mode),
      .req_address_offset     (req_address_offset),
      .req_write_value        (req_write_value),
      .req_claimed            (req_claimed),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_read_data          (rsp_read_data),
      .rsp_source             (rsp_source),
      .rsp_total_reads        (rsp_total_reads),
      .rsp_total_writes       (rsp_total_writes),
      .rsp_distinct_addresses (rsp_distinct_addresses),
      .mismatch_count         (mismatch_count),
      .owed_count             (owed_count)
   );

   // Response back-pressure: after each taken response ready may be dropped for a
   // stall drawn at random; now and then run a stretch with ready held high.
   always @(posedge clock) begin : rsp_side
      int unsigned n;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            if (rsp_calm != 0) begin
               rsp_calm <= rsp_calm - 1;
            end else if ($urandom_range(0, 40) == 0) begin
               rsp_calm <= $urandom_range(20, 80);
            end else begin
               n = $urandom_range(0, 8);
               if (n != 0) begin
                  rsp_ready <= 1'b0;
                  rsp_hold <= n;
               end
            end
         end
      end else begin
         if (rsp_hold > 1) rsp_hold <= rsp_hold - 1;
         else rsp_ready <= 1'b1;
      end
   end

   function automatic logic [1:0] pick_mode();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return MODE_READ;
      if (r < 75) return MODE_WRITE;
      if (r < 95) return MODE_PEEK;
      return MODE_NONE;
   endfunction

   // corner values turn up often enough to matter
   function automatic logic [31:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom();
   endfunction

   // One request: random lead-in gap (skipped in calm stretches), then hold
   // valid and payload until the edge that takes it. Valid is only lowered
   // when a gap follows, so back-to-back requests keep it high.
   task automatic send_access(input logic [1:0] mode, input logic [31:0] offset,
                              input logic [31:0] wval, input logic claimed);
      int unsigned gap;
      if (send_calm != 0) begin
         send_calm--;
         gap = 0;
      end else if ($urandom_range(0, 50) == 0) begin
         send_calm = $urandom_range(20, 80);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 8);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_address_offset <= offset;
      req_write_value <= wval;
      req_claimed <= claimed;
      do @(posedge clock); while (!req_ready);
   endtask

   // Sender holds off until every outstanding response has come back,
   // then lets the block go idle.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Only called with the block idle. Settle gets junk in its upper bits,
   // which the block must drop.
   task automatic set_shadow_config(input logic [31:0] base, input logic [7:0] settle,
                                    input logic [31:0] qa, input logic [31:0] qb,
                                    input logic [31:0] mask);
      put_csr(CSR_PERIPH_BASE, base);
      put_csr(CSR_SETTLE, {24'($urandom()), settle});
      put_csr(CSR_QUIRK_A, qa);
      put_csr(CSR_QUIRK_B, qb);
      put_csr(CSR_QUIRK_MASK, mask);
      csr_we <= 1'b0;
      cur_base = base;
      cur_settle = settle;
      cur_qa = qa;
      cur_qb = qb;
   endtask

   // Random traffic over a small address pool (both quirk registers, the
   // wrap-around offset and a few others) so slots get reused; bursts on one
   // address often outrun the settle limit.
   task automatic exercise_phase(input int unsigned count);
      logic [31:0] pool [12];
      logic [31:0] offset;
      int unsigned sent;
      int unsigned burst;
      int unsigned burst_cap;
      pool[0] = cur_qa - cur_base;
      pool[1] = cur_qb - cur_base;
      pool[2] = 32'h0;
      pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < 8; i++) pool[i] = $urandom_range(0, 63) * 4;
      for (int i = 8; i < 12; i++) pool[i] = $urandom();
      burst_cap = (cur_settle + 4 > 16) ? 16 : cur_settle + 4;
      sent = 0;
      while (sent < count) begin
         offset = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 11)] : $urandom();
         burst = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3)
                                             : $urandom_range(1, burst_cap);
         repeat (burst) begin
            send_access(pick_mode(), offset, pick_value(), $urandom_range(0, 9) == 0);
            sent++;
         end
         if ($urandom_range(0, 120) == 0) drain();
      end
   endtask

   initial begin : stimulus
      logic [31:0] base;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset register values ---
      send_access(MODE_PEEK, 32'h0, 32'h0, 1'b0);         // never seen: 0
      send_access(MODE_READ, 32'h0, 32'h0, 1'b0);         // new slot, unwritten: toggle
      send_access(MODE_WRITE, 32'h0, 32'hFFFF_FFFF, 1'b0);
      send_access(MODE_READ, 32'h0, 32'h0, 1'b0);         // stored value
      send_access(MODE_PEEK, 32'h0, 32'h0, 1'b1);         // peek ignores claimed
      send_access(MODE_WRITE, QA_OFF, 32'hDEAD_BEEF, 1'b0);
      send_access(MODE_READ, QA_OFF, 32'h0, 1'b0);        // key byte masked
      send_access(MODE_WRITE, QB_OFF, 32'hA5C3_0F96, 1'b0);
      send_access(MODE_READ, QB_OFF, 32'h0, 1'b0);
      send_access(MODE_PEEK, QB_OFF, 32'h0, 1'b0);        // peek is unmasked
      send_access(MODE_READ, 32'h0, 32'h0, 1'b1);         // claimed: totals only
      send_access(MODE_WRITE, 32'h0, 32'h1234_5678, 1'b1);
      send_access(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_access(MODE_READ, 32'hFFFF_FFFF, 32'h0, 1'b0); // address wraps
      send_access(MODE_WRITE, 32'hFFFF_FFFF, 32'h0, 1'b0);
      send_access(MODE_READ, 32'hFFFF_FFFF, 32'h0, 1'b0);
      send_access(MODE_READ, 32'h8, 32'h0, 1'b0);
      send_access(MODE_PEEK, 32'h8, 32'h0, 1'b0);         // allocated, unwritten
      drain();

      // --- random phases over several register settings ---
      exercise_phase(155);

      drain();
      set_shadow_config(32'h0, 8'd1, 32'h10, 32'h14, 32'h0);
      exercise_phase(155);

      drain();
      set_shadow_config(32'hFFFF_FFFF, 8'd255, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // one long same-slot run: past the settle limit and past the point
      // where a 9-bit run counter would wrap if it did not saturate
      send_access(MODE_WRITE, 32'h100, $urandom(), 1'b0);
      repeat (560)
         send_access(($urandom_range(0, 9) == 0) ? MODE_WRITE : MODE_READ, 32'h100,
                     $urandom(), $urandom_range(0, 19) == 0);
      exercise_phase(155);

      repeat (5) begin
         drain();
         base = $urandom();
         set_shadow_config(base, 8'($urandom_range(1, 10)),
                           base + $urandom_range(0, 63) * 4, $urandom(), $urandom());
         exercise_phase(155);
      end

      drain();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && owed_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin : watchdog
      #100_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
